### design/spqbp_pkg.sv
// shared types and constants for the stable priority queue batch pop unit
`default_nettype none
package spqbp_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 7;
   localparam int TAG_W  = 16;
   localparam int VAL_W  = 32;
   localparam int CMDQ_DEPTH = 2;

   localparam logic OP_PUSH    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // one request as it travels from front to back
   typedef struct packed {
      logic             operation;
      logic [TAG_W-1:0] item_tag;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
   } cmd_type;

   // command queue handshake toward the back end
   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } cmdq_type;

endpackage
`default_nettype wire

### design/spqbp_front.sv
// front end: accepts requests into a short command queue
`default_nettype none
module spqbp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire spqbp_pkg::cmd_type    req_cmd,
   output spqbp_pkg::cmdq_type        head,
   input  wire logic                  pop
);
   localparam int PTR_W = $clog2(spqbp_pkg::CMDQ_DEPTH);

   spqbp_pkg::cmd_type          slot_ff [spqbp_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]              fill_ff;
   logic                        push;

   // full queue holds off new requests
   assign busy = (fill_ff == (PTR_W+1)'(spqbp_pkg::CMDQ_DEPTH));
   assign push = start && !busy;

   assign head.avail = (fill_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_cmd;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) fill_ff <= fill_ff + 1'b1;
         else if (!push && pop) fill_ff <= fill_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

### design/spqbp_back.sv
// back end: item store, max scan, compaction and result register
`default_nettype none
module spqbp_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spqbp_pkg::cmdq_type               head,
   output logic                                   pop,
   output logic                                   rsp_strobe,
   output logic [spqbp_pkg::TAG_W-1:0]            rsp_item_tag_res,
   output logic [spqbp_pkg::VAL_W-1:0]            rsp_value_res,
   output logic                                   rsp_overflow,
   output logic                                   rsp_last
);
   localparam int AW = spqbp_pkg::ADDR_W;
   localparam int CW = spqbp_pkg::CNT_W;
   localparam int TW = spqbp_pkg::TAG_W;
   localparam int VW = spqbp_pkg::VAL_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT} state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         occ_ff, occ_in, rem_ff, rem_in, idx_ff, idx_in;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]         pipe_idx_ff, pipe_idx_in;
   logic [VW-1:0]         best_val_ff, best_val_in;
   logic [TW-1:0]         best_tag_ff, best_tag_in;
   logic [AW-1:0]         best_slot_ff, best_slot_in;
   logic                  rsp_strobe_in, rsp_overflow_in, rsp_last_in;
   logic [TW-1:0]         rsp_tag_in;
   logic [VW-1:0]         rsp_val_in;

   logic [TW+VW-1:0]      mem [spqbp_pkg::DEPTH];
   logic [TW+VW-1:0]      rd_data_ff, mem_wdata;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic                  issue;
   logic [VW-1:0]         rd_val;
   logic [TW-1:0]         rd_tag;

   assign rd_tag = rd_data_ff[TW+VW-1:VW];
   assign rd_val = rd_data_ff[VW-1:0];
   assign issue  = idx_ff < occ_ff;

   // item store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = idx_ff[AW-1:0];
      best_val_in  = best_val_ff;
      best_tag_in  = best_tag_ff;
      best_slot_in = best_slot_ff;
      rsp_strobe_in   = 1'b0;
      rsp_overflow_in = 1'b0;
      rsp_last_in     = 1'b0;
      rsp_tag_in      = rsp_item_tag_res;
      rsp_val_in      = rsp_value_res;
      mem_we    = 1'b0;
      mem_waddr = occ_ff[AW-1:0];
      mem_wdata = {head.cmd.item_tag, head.cmd.value};
      mem_raddr = idx_ff[AW-1:0];
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.avail) begin
               pop = 1'b1;
               if (head.cmd.operation == spqbp_pkg::OP_PUSH) begin
                  if (occ_ff == CW'(spqbp_pkg::DEPTH)) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_overflow_in = 1'b1;
                     rsp_last_in     = 1'b1;
                     rsp_tag_in      = head.cmd.item_tag;
                     rsp_val_in      = head.cmd.value;
                  end else begin
                     mem_we = 1'b1;
                     occ_in = occ_ff + 1'b1;
                  end
               end else if (head.cmd.count != '0 && occ_ff != '0) begin
                  rem_in   = head.cmd.count;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read one slot per cycle, compare it in the next cycle
            if (issue) begin
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
            if (pipe_vld_ff && (pipe_idx_ff == '0 || rd_val > best_val_ff)) begin
               best_val_in  = rd_val;
               best_tag_in  = rd_tag;
               best_slot_in = pipe_idx_ff;
            end
            if (!issue && !pipe_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_tag_in    = best_tag_ff;
               rsp_val_in    = best_val_ff;
               rsp_last_in   = (rem_ff == CW'(1)) || (occ_ff == CW'(1));
               idx_in        = CW'(best_slot_ff) + 1'b1;
               state_in      = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // move the slots above the removed one down by one
            if (issue) begin
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
            if (pipe_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pipe_idx_ff - 1'b1;
               mem_wdata = rd_data_ff;
            end
            if (!issue && !pipe_vld_ff) begin
               occ_in = occ_ff - 1'b1;
               rem_in = rem_ff - 1'b1;
               idx_in = '0;
               if (rem_ff == CW'(1) || occ_ff == CW'(1)) state_in = ST_IDLE;
               else state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         occ_ff      <= '0;
         rem_ff      <= '0;
         idx_ff      <= '0;
         pipe_vld_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         occ_ff      <= occ_in;
         rem_ff      <= rem_in;
         idx_ff      <= idx_in;
         pipe_vld_ff <= pipe_vld_in;
         rsp_strobe  <= rsp_strobe_in;
      end
      pipe_idx_ff      <= pipe_idx_in;
      best_val_ff      <= best_val_in;
      best_tag_ff      <= best_tag_in;
      best_slot_ff     <= best_slot_in;
      rsp_overflow     <= rsp_overflow_in;
      rsp_last         <= rsp_last_in;
      rsp_item_tag_res <= rsp_tag_in;
      rsp_value_res    <= rsp_val_in;
   end

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(spqbp_pkg::DEPTH))
      else $error("occupancy above depth");
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overflow |-> rsp_last)
      else $error("overflow result without last");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE && head.avail)
      else $error("pop outside idle");
   a_rel_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_overflow |-> state_ff == ST_SHIFT)
      else $error("release result without compaction");
endmodule
`default_nettype wire

### design/stable_priority_queue_batch_pop_unit.sv
// top level: stable max priority queue with batch release
//
// Request channel: a request is taken at a clock edge with start high and
// busy low. req_operation 0 pushes req_item_tag/req_value, 1 releases up to
// req_count items. Requests wait in a two-entry command queue, so busy only
// rises when that queue is full.
// Result channel: each result shows for one cycle with rsp_strobe high and
// cannot be held off. Released items come highest value first, oldest first
// among equal values; rsp_last marks the final result of a request.
// A push into a full queue gives one result with rsp_overflow and rsp_last.
// A push writes one slot of the item store. Each released item is found by
// reading every stored item and picking the maximum, then compacting the
// slots above it. The store gives one registered read per cycle.
// Reset: synchronous, empties the queue and the command queue; the item
// store itself is not cleared.
`default_nettype none
module stable_priority_queue_batch_pop_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [spqbp_pkg::TAG_W-1:0]    req_item_tag,
   input  wire logic [spqbp_pkg::VAL_W-1:0]    req_value,
   input  wire logic [spqbp_pkg::CNT_W-1:0]    req_count,
   output logic                                rsp_strobe,
   output logic [spqbp_pkg::TAG_W-1:0]         rsp_item_tag_res,
   output logic [spqbp_pkg::VAL_W-1:0]         rsp_value_res,
   output logic                                rsp_overflow,
   output logic                                rsp_last
);
   spqbp_pkg::cmd_type  req_cmd;
   spqbp_pkg::cmdq_type head;
   logic                pop;

   assign req_cmd.operation = req_operation;
   assign req_cmd.item_tag  = req_item_tag;
   assign req_cmd.value     = req_value;
   assign req_cmd.count     = req_count;

   spqbp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .req_cmd (req_cmd),
      .head    (head),
      .pop     (pop)
   );

   spqbp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_item_tag_res (rsp_item_tag_res),
      .rsp_value_res    (rsp_value_res),
      .rsp_overflow     (rsp_overflow),
      .rsp_last         (rsp_last)
   );
endmodule
`default_nettype wire
